// ----- rtl/core/ckrs_pkg.sv -----
// Shared types, register indexes, reset values and duty arithmetic for the
// claw and kick ramp sequencer. No dependencies.
`timescale 1ns / 1ps

package ckrs_pkg;

	// Default duty counter width
	localparam int DUTY_BITS_DEF = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 1'd1;

	// Register reset values
	localparam logic [15:0] PERIOD_RST = 16'd4000;
	localparam logic [15:0] STEP_RST   = 16'd200;

	// Orders; FIN marks an order that reports done on its next step
	typedef enum logic [1:0] {
		ORD_OPEN  = 2'd0,
		ORD_CLOSE = 2'd1,
		ORD_KICK  = 2'd2,
		ORD_FIN   = 2'd3
	} order_t;

	// Sequencer control state
	typedef struct packed {
		logic   moving;
		order_t order;
		logic   opened;
		logic   kicked;
		logic   retracted;
	} ctrl_t;

	// Add with saturation at a limit
	function automatic logic [16:0] rise(logic [16:0] v, logic [16:0] inc,
			logic [16:0] lim);
		logic [16:0] sum;
		sum = v + inc;
		return (sum < lim) ? sum : lim;
	endfunction

	// Subtract with floor at zero
	function automatic logic [16:0] fall(logic [16:0] v, logic [16:0] dec);
		return (v > dec) ? (v - dec) : 17'd0;
	endfunction

endpackage

// ----- rtl/core/ckrs_step.sv -----
// Next-state logic for one sequencer step: order load, claw and kick ramps,
// kick phase flags and done. Depends on ckrs_pkg.
`timescale 1ns / 1ps

module ckrs_step import ckrs_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF,
	localparam int LVL_W = (DUTY_BITS < 16) ? DUTY_BITS : 16
) (
	input  ctrl_t             cur,
	input  logic [LVL_W-1:0]  claw_cur,
	input  logic [LVL_W-1:0]  kick_cur,
	input  logic              func,
	input  logic [1:0]        order,
	input  logic [15:0]       period,
	input  logic [15:0]       step,
	output ctrl_t             nxt,
	output logic [LVL_W-1:0]  claw_nxt,
	output logic [LVL_W-1:0]  kick_nxt,
	output logic              done
);

	localparam logic [16:0] LVL_MAX = 17'((64'd1 << LVL_W) - 64'd1);

	logic [16:0] period_x;
	logic [16:0] claw_lim;
	logic [16:0] kick_lim;
	logic [16:0] step_x;
	logic [16:0] half_x;
	logic [16:0] claw_x;
	logic [16:0] kick_x;
	logic [LVL_W-1:0] claw_up;
	logic [LVL_W-1:0] claw_dn;
	logic [LVL_W-1:0] kick_up;
	logic [LVL_W-1:0] kick_dn;

	// Limits, capped to the duty counter range
	assign period_x = {1'b0, period};
	assign claw_lim = (period_x < LVL_MAX) ? period_x : LVL_MAX;
	assign kick_lim = ((period_x >> 1) < LVL_MAX) ? (period_x >> 1) : LVL_MAX;

	// Step sizes; retraction uses half a step, never less than one
	assign step_x = {1'b0, step};
	assign half_x = (step[15:1] == 15'd0) ? 17'd1 : {2'b00, step[15:1]};

	assign claw_x = 17'(claw_cur);
	assign kick_x = 17'(kick_cur);

	// Candidate ramp values; all stay within the limits, so they fit LVL_W
	assign claw_up = LVL_W'(rise(claw_x, step_x, claw_lim));
	assign claw_dn = LVL_W'(fall(claw_x, step_x));
	assign kick_up = LVL_W'(rise(kick_x, step_x, kick_lim));
	assign kick_dn = LVL_W'(fall(kick_x, half_x));

	// Advance the order by one step
	always_comb begin
		nxt      = cur;
		claw_nxt = claw_cur;
		kick_nxt = kick_cur;
		done     = 1'b0;
		if (!cur.moving) begin
			if (func) begin
				nxt.order  = order_t'(order);
				nxt.moving = 1'b1;
			end
		end else begin
			case (cur.order)
				ORD_OPEN: begin
					if (claw_x < claw_lim) claw_nxt = claw_up;
					else nxt.order = ORD_FIN;
				end
				ORD_CLOSE: begin
					if (claw_x != 17'd0) claw_nxt = claw_dn;
					else nxt.order = ORD_FIN;
				end
				ORD_KICK: begin
					if (!cur.opened) begin
						if (claw_x < claw_lim) claw_nxt = claw_up;
						else nxt.opened = 1'b1;
					end else if (!cur.kicked) begin
						if (kick_x < kick_lim) kick_nxt = kick_up;
						else nxt.kicked = 1'b1;
					end else if (!cur.retracted) begin
						if (kick_x != 17'd0) kick_nxt = kick_dn;
						else nxt.retracted = 1'b1;
					end else begin
						nxt.opened    = 1'b0;
						nxt.kicked    = 1'b0;
						nxt.retracted = 1'b0;
						nxt.order     = ORD_FIN;
					end
				end
				default: begin
					done       = 1'b1;
					nxt.moving = 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/claw_kick_ramp_sequencer.sv -----
// Top level of the claw and kick ramp sequencer: configuration registers,
// input register, state and result register. Depends on ckrs_pkg, ckrs_step.
`timescale 1ns / 1ps

// Each accepted transaction (timer tick or control command) yields exactly one
// result carrying both PWM duties, a done flag and a busy flag. The block takes
// one transaction per clock while the result channel does not stall: the
// transaction sits in the input register while the step logic works on it, and
// then the result register takes the step logic output. The rate is set by
// the loop from the sequencer state through the step logic back into the state,
// one step per clock. Stall on the result channel holds both stages; while the
// input register is empty a new transaction is still taken. Write period and
// step only while no transaction is in flight.
module claw_kick_ramp_sequencer import ckrs_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic                 func,
	input  logic [1:0]           order,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [15:0]          grip_duty,
	output logic [15:0]          kick_duty,
	output logic                 done_res,
	output logic                 busy_res
);

	localparam int LVL_W = (DUTY_BITS < 16) ? DUTY_BITS : 16;

	logic [15:0] period_q;
	logic [15:0] step_q;

	logic        s1_valid_q;
	logic        func_s1;
	logic [1:0]  order_s1;

	ctrl_t             ctrl_q;
	ctrl_t             ctrl_nxt;
	logic [LVL_W-1:0]  claw_q;
	logic [LVL_W-1:0]  kick_q;
	logic [LVL_W-1:0]  claw_nxt;
	logic [LVL_W-1:0]  kick_nxt;
	logic              done_nxt;

	logic              res_valid_q;
	logic [15:0]       grip_duty_q;
	logic [15:0]       kick_duty_q;
	logic              done_q;
	logic              busy_q;

	logic              adv;
	logic              cmd_acc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			step_q   <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PERIOD: period_q <= cfg_data;
				CFG_STEP:   step_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Pipeline moves whenever the result register is free or being taken
	assign adv       = !res_valid_q || !res_stall;
	assign cmd_stall = s1_valid_q && !adv;
	assign cmd_acc   = cmd_valid && !cmd_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd_acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			func_s1  <= func;
			order_s1 <= order;
		end
	end

	ckrs_step #(
		.DUTY_BITS (DUTY_BITS)
	) u_step (
		.cur      (ctrl_q),
		.claw_cur (claw_q),
		.kick_cur (kick_q),
		.func     (func_s1),
		.order    (order_s1),
		.period   (period_q),
		.step     (step_q),
		.nxt      (ctrl_nxt),
		.claw_nxt (claw_nxt),
		.kick_nxt (kick_nxt),
		.done     (done_nxt)
	);

	// Sequencer state: advance once per transaction leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '{moving: 1'b0, order: ORD_OPEN, opened: 1'b0,
				kicked: 1'b0, retracted: 1'b0};
			claw_q <= '0;
			kick_q <= '0;
		end else if (adv && s1_valid_q) begin
			ctrl_q <= ctrl_nxt;
			claw_q <= claw_nxt;
			kick_q <= kick_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			grip_duty_q <= 16'(claw_nxt);
			kick_duty_q <= 16'(kick_nxt);
			done_q      <= done_nxt;
			busy_q      <= ctrl_nxt.moving;
		end
	end

	assign res_valid = res_valid_q;
	assign grip_duty = grip_duty_q;
	assign kick_duty = kick_duty_q;
	assign done_res  = done_q;
	assign busy_res  = busy_q;

	// Kick phase flags are set in order and cleared together
	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!ctrl_q.retracted || ctrl_q.kicked) && (!ctrl_q.kicked || ctrl_q.opened))
		else $error("kick phase flags out of order");

	// Phase flags only live during a kick order
	a_flag_kick: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.opened |-> (ctrl_q.moving && ctrl_q.order == ORD_KICK))
		else $error("phase flag set outside a kick order");

	// A finishing step always leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && done_res) |-> !busy_res)
		else $error("done reported while still busy");

	// An empty input register never stalls the command channel
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> !cmd_stall)
		else $error("command stalled with empty input register");

endmodule
